/* sv/palindromic_tree_builder_defines.svh */
// Assertion macros shared by the palindromic tree builder checker.
`ifndef PALINDROMIC_TREE_BUILDER_DEFINES_SVH
`define PALINDROMIC_TREE_BUILDER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PTB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ptb port check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PTB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ptb port check failed");

`endif

/* sv/ptb_pkg.sv */
// Shared types and constants for the palindromic tree builder.
package ptb_pkg;

    localparam int LETTER_W = 5;
    localparam int OUT_W    = 13;
    localparam int COUNT_W  = 13;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Node record read port address select
    typedef enum logic [1:0] {
        RD_CUR  = 2'd0,
        RD_CAND = 2'd1,
        RD_NODE = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    take;          // valid letter accepted
        logic    take_rpt;      // out-of-range or overflow word accepted
        t_rd_sel rd_sel;
        logic    save_rec;      // latch length/link of walk node
        logic    follow_now;    // walk node <= link just read
        logic    follow_saved;  // walk node <= latched link
        logic    ea_calc;       // edge address of walk node
        logic    found;         // first walk done: keep p
        logic    hit;           // edge exists: result is its child
        logic    walk2;         // start second walk at link of p
        logic    link_cand;     // new link <= verified edge child
        logic    link_zero;     // new link <= even root
        logic    new_node;      // write new node record and edge
        logic    finish;        // count update and result load
    } t_cmd;

    typedef struct packed {
        logic letter_ok;
        logic full;
        logic p_odd;       // walk node is the odd root
        logic idx_pos;     // mirror position lies inside the text
        logic txt_match;
        logic cand_ok;     // edge child verified against its record
        logic p_is_odd;    // extended node is the odd root
        logic out_free;
    } t_sts;

endpackage

/* sv/ptb_ctrl.sv */
// Sequencer for the palindromic tree builder: walks, edge lookup, node creation.
module ptb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ptb_pkg::t_sts   i_sts,
    output ptb_pkg::t_cmd   o_cmd,
    output logic            o_stall
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_WREC  = 11'b000_0000_0010,
        S_WCHK  = 11'b000_0000_0100,
        S_WTXT  = 11'b000_0000_1000,
        S_EADDR = 11'b000_0001_0000,
        S_EREAD = 11'b000_0010_0000,
        S_EVER  = 11'b000_0100_0000,
        S_ECHK  = 11'b000_1000_0000,
        S_NEWND = 11'b001_0000_0000,
        S_RDOUT = 11'b010_0000_0000,
        S_FIN   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_phase2, n_phase2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase2 <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase2 <= n_phase2;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_phase2 = r_phase2;
        o_cmd    = '0;
        o_cmd.rd_sel = ptb_pkg::RD_CUR;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_sts.letter_ok && !i_sts.full) begin
                        o_cmd.take = 1'b1;
                        n_phase2   = 1'b0;
                        n_state    = S_WREC;
                    end else begin
                        o_cmd.take_rpt = 1'b1;
                        n_state        = S_RDOUT;
                    end
                end
            end
            S_WREC: begin
                n_state = S_WCHK;
            end
            S_WCHK: begin
                o_cmd.save_rec = 1'b1;
                if (i_sts.p_odd) begin
                    n_state = S_EADDR;
                end else if (!i_sts.idx_pos) begin
                    o_cmd.follow_now = 1'b1;
                    n_state          = S_WREC;
                end else begin
                    n_state = S_WTXT;
                end
            end
            S_WTXT: begin
                if (i_sts.txt_match) begin
                    n_state = S_EADDR;
                end else begin
                    o_cmd.follow_saved = 1'b1;
                    n_state            = S_WREC;
                end
            end
            S_EADDR: begin
                o_cmd.ea_calc = 1'b1;
                o_cmd.found   = !r_phase2;
                n_state       = S_EREAD;
            end
            S_EREAD: begin
                n_state = S_EVER;
            end
            S_EVER: begin
                o_cmd.rd_sel = ptb_pkg::RD_CAND;
                n_state      = S_ECHK;
            end
            S_ECHK: begin
                if (r_phase2) begin
                    o_cmd.link_cand = 1'b1;
                    n_state         = S_NEWND;
                end else if (i_sts.cand_ok) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_RDOUT;
                end else if (i_sts.p_is_odd) begin
                    o_cmd.link_zero = 1'b1;
                    n_state         = S_NEWND;
                end else begin
                    o_cmd.walk2 = 1'b1;
                    n_phase2    = 1'b1;
                    n_state     = S_WREC;
                end
            end
            S_NEWND: begin
                o_cmd.new_node = 1'b1;
                n_state        = S_RDOUT;
            end
            S_RDOUT: begin
                o_cmd.rd_sel = ptb_pkg::RD_NODE;
                n_state      = S_FIN;
            end
            S_FIN: begin
                o_cmd.rd_sel = ptb_pkg::RD_NODE;
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/ptb_dp.sv */
// Datapath for the palindromic tree builder: stores, walk registers, result register.
module ptb_dp #(
    parameter int MAX_LEN  = 4096,
    parameter int ALPHABET = 26
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ptb_pkg::t_cmd                     i_cmd,
    output ptb_pkg::t_sts                     o_sts,
    input  logic [ptb_pkg::LETTER_W-1:0]      i_letter,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [ptb_pkg::OUT_W-1:0]         o_suffix_node,
    output logic [ptb_pkg::OUT_W-1:0]         o_palindrome_length,
    output logic                              o_node_created,
    output logic [ptb_pkg::OUT_W-1:0]         o_occurrences,
    output logic                              o_overflow
);

    localparam int NODE_CAP   = MAX_LEN + 2;
    localparam int NW         = $clog2(NODE_CAP);
    localparam int PW         = $clog2(MAX_LEN + 1);
    localparam int LW         = PW + 1;
    localparam int EDGE_DEPTH = NODE_CAP * ALPHABET;
    localparam int EW         = $clog2(EDGE_DEPTH);
    localparam int CW         = ptb_pkg::COUNT_W;
    localparam int AW         = ptb_pkg::LETTER_W;

    // control state
    logic [PW-1:0] r_pos;
    logic [NW-1:0] r_last;
    logic [NW-1:0] r_total;
    logic          r_ovalid;

    // walk and node registers
    logic [NW-1:0]        r_cur;
    logic [AW-1:0]        r_c;
    logic signed [LW-1:0] r_len_cur;
    logic [NW-1:0]        r_link_cur;
    logic [NW-1:0]        r_p;
    logic signed [LW-1:0] r_len_p;
    logic [NW-1:0]        r_plink;
    logic [EW-1:0]        r_ea;
    logic [EW-1:0]        r_ea_p;
    logic [NW-1:0]        r_newlink;
    logic [NW-1:0]        r_node;
    logic                 r_inc;
    logic                 r_fresh;
    logic                 r_ovf;

    // result register
    logic [ptb_pkg::OUT_W-1:0] r_o_node;
    logic [ptb_pkg::OUT_W-1:0] r_o_len;
    logic                      r_o_created;
    logic [ptb_pkg::OUT_W-1:0] r_o_occ;
    logic                      r_o_ovf;

    // stores
    logic [AW-1:0] r_txt_mem  [0:MAX_LEN];
    logic [PW-1:0] r_len_mem  [0:NODE_CAP-1];
    logic [NW-1:0] r_link_mem [0:NODE_CAP-1];
    logic [NW-1:0] r_par_mem  [0:NODE_CAP-1];
    logic [AW-1:0] r_chr_mem  [0:NODE_CAP-1];
    logic [CW-1:0] r_cnt_mem  [0:NODE_CAP-1];
    logic [NW-1:0] r_edge_mem [0:EDGE_DEPTH-1];

    logic [AW-1:0] r_txt_rd;
    logic [PW-1:0] r_len_rd;
    logic [NW-1:0] r_link_rd;
    logic [NW-1:0] r_par_rd;
    logic [AW-1:0] r_chr_rd;
    logic          r_rd_root0;
    logic          r_rd_root1;
    logic [CW-1:0] r_cnt_rd;
    logic [NW-1:0] r_edge_rd;

    logic [NW-1:0]        w_rd_addr;
    logic signed [LW-1:0] w_len;
    logic [NW-1:0]        w_link;
    logic signed [LW:0]   w_idx;
    logic [PW-1:0]        w_pos_next;
    logic [EW-1:0]        w_ea;
    logic signed [LW-1:0] w_nlen;
    logic [NW-1:0]        w_total_next;
    logic                 w_cand_ok;
    logic [CW-1:0]        w_cnt_base;
    logic [CW-1:0]        w_cnt_new;

    always_comb begin
        case (i_cmd.rd_sel)
            ptb_pkg::RD_CUR:  w_rd_addr = r_cur;
            ptb_pkg::RD_CAND: w_rd_addr = r_edge_rd;
            ptb_pkg::RD_NODE: w_rd_addr = r_node;
            default:          w_rd_addr = r_cur;
        endcase
    end

    // roots are not stored: odd root has length -1, links cross
    assign w_len  = r_rd_root1 ? {LW{1'b1}} :
                    r_rd_root0 ? '0 : $signed({1'b0, r_len_rd});
    assign w_link = r_rd_root0 ? NW'(1) : (r_rd_root1 ? '0 : r_link_rd);

    assign w_idx        = $signed({2'b00, r_pos}) - (LW+1)'(w_len) - (LW+1)'(1);
    assign w_pos_next   = r_pos + PW'(1);
    assign w_ea         = EW'(EW'(r_cur) * EW'(ALPHABET)) + EW'(r_c) - EW'(1);
    assign w_nlen       = r_len_p + LW'(2);
    assign w_total_next = r_total + NW'(1);

    assign w_cand_ok = (r_edge_rd >= NW'(2)) && (r_edge_rd <= r_total) &&
                       (r_par_rd == r_cur) && (r_chr_rd == r_c);

    assign w_cnt_base = (r_fresh || r_rd_root0 || r_rd_root1) ? '0 : r_cnt_rd;
    assign w_cnt_new  = (r_inc && (w_cnt_base != ptb_pkg::COUNT_MAX)) ?
                        w_cnt_base + CW'(1) : w_cnt_base;

    always_comb begin
        o_sts.letter_ok = (i_letter != '0) && (int'(i_letter) <= ALPHABET);
        o_sts.full      = (r_pos == PW'(MAX_LEN));
        o_sts.p_odd     = (r_cur == NW'(1));
        o_sts.idx_pos   = !w_idx[LW] && (w_idx != '0);
        o_sts.txt_match = (r_txt_rd == r_c);
        o_sts.cand_ok   = w_cand_ok;
        o_sts.p_is_odd  = (r_p == NW'(1));
        o_sts.out_free  = !r_ovalid || !i_stall;
    end

    // text store, slot zero is never written
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_txt_mem[w_pos_next] <= i_letter;
        end
        r_txt_rd <= r_txt_mem[w_idx[PW-1:0]];
    end

    // node records, written once when the node is made
    always_ff @(posedge i_clk) begin
        if (i_cmd.new_node) begin
            r_len_mem[w_total_next]  <= w_nlen[PW-1:0];
            r_link_mem[w_total_next] <= r_newlink;
            r_par_mem[w_total_next]  <= r_p;
            r_chr_mem[w_total_next]  <= r_c;
        end
        r_len_rd   <= r_len_mem[w_rd_addr];
        r_link_rd  <= r_link_mem[w_rd_addr];
        r_par_rd   <= r_par_mem[w_rd_addr];
        r_chr_rd   <= r_chr_mem[w_rd_addr];
        r_rd_root0 <= (w_rd_addr == '0);
        r_rd_root1 <= (w_rd_addr == NW'(1));
    end

    // occurrence counts
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_inc) begin
            r_cnt_mem[r_node] <= w_cnt_new;
        end
        r_cnt_rd <= r_cnt_mem[r_node];
    end

    // child edges
    always_ff @(posedge i_clk) begin
        if (i_cmd.new_node) begin
            r_edge_mem[r_ea_p] <= w_total_next;
        end
        r_edge_rd <= r_edge_mem[r_ea];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_last   <= '0;
            r_total  <= NW'(1);
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_pos <= w_pos_next;
            end
            if (i_cmd.new_node) begin
                r_total <= w_total_next;
            end
            if (i_cmd.finish) begin
                r_last   <= r_node;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_cur <= r_last;
            r_c   <= i_letter;
            r_ovf <= 1'b0;
        end
        if (i_cmd.take_rpt) begin
            r_node  <= r_last;
            r_inc   <= 1'b0;
            r_fresh <= 1'b0;
            r_ovf   <= o_sts.letter_ok;
        end
        if (i_cmd.save_rec) begin
            r_len_cur  <= w_len;
            r_link_cur <= w_link;
        end
        if (i_cmd.follow_now) begin
            r_cur <= w_link;
        end
        if (i_cmd.follow_saved) begin
            r_cur <= r_link_cur;
        end
        if (i_cmd.ea_calc) begin
            r_ea <= w_ea;
        end
        if (i_cmd.found) begin
            r_p     <= r_cur;
            r_len_p <= r_len_cur;
            r_plink <= r_link_cur;
            r_ea_p  <= w_ea;
        end
        if (i_cmd.hit) begin
            r_node  <= r_edge_rd;
            r_inc   <= 1'b1;
            r_fresh <= 1'b0;
        end
        if (i_cmd.walk2) begin
            r_cur <= r_plink;
        end
        if (i_cmd.link_cand) begin
            r_newlink <= w_cand_ok ? r_edge_rd : '0;
        end
        if (i_cmd.link_zero) begin
            r_newlink <= '0;
        end
        if (i_cmd.new_node) begin
            r_node  <= w_total_next;
            r_inc   <= 1'b1;
            r_fresh <= 1'b1;
        end
        if (i_cmd.finish) begin
            r_o_node    <= ptb_pkg::OUT_W'(r_node);
            r_o_len     <= ptb_pkg::OUT_W'(w_len);
            r_o_created <= r_fresh;
            r_o_occ     <= ptb_pkg::OUT_W'(w_cnt_new);
            r_o_ovf     <= r_ovf;
        end
    end

    assign o_valid             = r_ovalid;
    assign o_suffix_node       = r_o_node;
    assign o_palindrome_length = r_o_len;
    assign o_node_created      = r_o_created;
    assign o_occurrences       = r_o_occ;
    assign o_overflow          = r_o_ovf;

endmodule

/* sv/palindromic_tree_builder.sv */
// A letter walks the suffix links from the last node and looks up one edge, then its word loads;
// a new node adds a record write and, above length one, a second walk and edge lookup.
// Out-of-range letters and letters on a full text skip the walks and go straight to read-out.
// One letter at a time: the next is accepted once the word loads; a held word delays the load.
// Synchronous active-low reset clears position, last node and output valid, sets node total to 1;
// stores are not swept: an edge counts only if its child record names this parent/letter.
module palindromic_tree_builder #(
    parameter int MAX_LEN  = 4096,
    parameter int ALPHABET = 26
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // letter channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ptb_pkg::LETTER_W-1:0]  i_letter,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ptb_pkg::OUT_W-1:0]     o_suffix_node,
    output logic [ptb_pkg::OUT_W-1:0]     o_palindrome_length,
    output logic                          o_node_created,
    output logic [ptb_pkg::OUT_W-1:0]     o_occurrences,
    output logic                          o_overflow
);

    // Controller steps the eertree update:
    //   accept -> walk from last node until the letter mirrors around the node
    //   -> look up edge (p, letter); a hit ends the update on that child
    //   -> on a miss, unless p is the odd root, a second walk from link(p) finds the new node's link
    //   -> write node record and edge, then read out and bump the count.
    // The datapath owns all stores and the result register. The result
    // register frees the controller only when the previous word is gone.
    ptb_pkg::t_cmd w_cmd;
    ptb_pkg::t_sts w_sts;

    ptb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_stall (o_stall)
    );

    // Node ids and lengths wider than the result fields are truncated there.
    // Node records, counts and edges live in memories with one read port each;
    // the two roots are constants and never occupy record entries.
    ptb_dp #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_letter            (i_letter),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_suffix_node       (o_suffix_node),
        .o_palindrome_length (o_palindrome_length),
        .o_node_created      (o_node_created),
        .o_occurrences       (o_occurrences),
        .o_overflow          (o_overflow)
    );

endmodule

/* sv/ptb_checker.sv */
// Port-level checks for the palindromic tree builder, bound to the top level.
`include "palindromic_tree_builder_defines.svh"

module ptb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [4:0]  i_letter,
    input logic        o_valid,
    input logic        i_stall,
    input logic [12:0] o_suffix_node,
    input logic [12:0] o_palindrome_length,
    input logic        o_node_created,
    input logic [12:0] o_occurrences,
    input logic        o_overflow
);

    // a taken word always makes the block busy in the next cycle
    `PTB_ASSERT_NEXT(a_busy_after_take, i_valid && !o_stall, o_stall)

    // a held result keeps its fields
    `PTB_ASSERT_NEXT(a_out_held, o_valid && i_stall, o_valid && $stable(o_suffix_node) && $stable(o_occurrences))

    // a new result shows up together with readiness for the next letter
    `PTB_ASSERT_NOW(a_rise_with_ready, $rose(o_valid), !o_stall)

    // a freshly made node has been seen exactly once and no overflow
    `PTB_ASSERT_NOW(a_new_node_count, o_valid && o_node_created, !o_overflow && o_occurrences == 13'd1)

endmodule

bind palindromic_tree_builder ptb_checker u_ptb_checker (.*);
